/* design/noise_displacement_address_gen_unit_assert.svh */
// assertion macros for the displacement address generator
`ifndef NOISE_DISPLACEMENT_ADDRESS_GEN_UNIT_ASSERT_SVH
`define NOISE_DISPLACEMENT_ADDRESS_GEN_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define NDAG_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("ndag assertion failed");
`define NDAG_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("ndag assertion failed");
`else
`define NDAG_ASSERT(label, clk, rst, prop)
`define NDAG_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

/* design/ndag_pkg.sv */
package ndag_pkg;

   localparam int PIX_W   = 12;
   localparam int COORD_W = 14;
   localparam int DIM_W   = 13;
   localparam int SCALE_W = 16;
   localparam int LAT_W   = 8;
   localparam int DISP_W  = 10;

   localparam logic [31:0] HASH_MUL_X = 32'd1619;
   localparam logic [31:0] HASH_MUL_Y = 32'd31337;
   localparam int          HASH_SHIFT = 13;
   localparam logic [31:0] HASH_MUL_Q = 32'd15731;
   localparam logic [31:0] HASH_ADD_Q = 32'd789221;
   localparam logic [31:0] HASH_ADD   = 32'd1376312589;
   localparam longint unsigned HASH_DIV = 64'd1376312589;

   localparam logic [DIM_W-1:0]   WIDTH_RESET  = 13'd4096;
   localparam logic [DIM_W-1:0]   HEIGHT_RESET = 13'd4096;
   localparam logic [SCALE_W-1:0] SCALE_RESET  = 16'd256;

   typedef enum logic [1:0] {
      REG_WIDTH  = 2'd0,
      REG_HEIGHT = 2'd1,
      REG_SCALE  = 2'd2
   } reg_index_type;

endpackage

/* design/ndag_hash.sv */
module ndag_hash #(
   parameter int F = 16
) (
   input  logic                            clock,
   input  logic                            ce,
   input  logic [ndag_pkg::LAT_W-1:0]      ix,
   input  logic [ndag_pkg::LAT_W-1:0]      iy,
   output logic signed [F+1:0]             noise
);
   localparam longint unsigned Recip =
      ((64'd1 << (F + 32)) + ndag_pkg::HASH_DIV / 2) / ndag_pkg::HASH_DIV;
   localparam logic [F+1:0] RecipC = (F+2)'(Recip);

   logic [31:0] n_in, n_a_ff, nn_ff, n_b_ff, m_ff, n_c_ff, base;
   logic [30:0] h_ff;
   logic [31:0] h_full;
   logic [F+32:0] prod;
   logic [F:0] v;
   logic signed [F+1:0] noise_ff, noise_in;

   always_comb begin
      base   = 32'(ix) * ndag_pkg::HASH_MUL_X + 32'(iy) * ndag_pkg::HASH_MUL_Y;
      n_in   = (base << ndag_pkg::HASH_SHIFT) ^ base;
      h_full = n_c_ff * m_ff + ndag_pkg::HASH_ADD;
      prod   = (F+33)'(h_ff) * (F+33)'(RecipC) + (F+33)'(64'h8000_0000);
      v      = prod[F+32:32];
      noise_in = $signed({2'b01, {F{1'b0}}}) - $signed({1'b0, v});
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         n_a_ff   <= n_in;
         nn_ff    <= n_a_ff * n_a_ff;
         n_b_ff   <= n_a_ff;
         m_ff     <= nn_ff * ndag_pkg::HASH_MUL_Q + ndag_pkg::HASH_ADD_Q;
         n_c_ff   <= n_b_ff;
         h_ff     <= h_full[30:0];
         noise_ff <= noise_in;
      end
   end

   assign noise = noise_ff;
endmodule

/* design/ndag_smooth.sv */
module ndag_smooth #(
   parameter int F = 16
) (
   input  logic         clock,
   input  logic         ce,
   input  logic [F-1:0] f,
   output logic [F:0]   u
);
   logic [2*F-1:0] t_raw_ff;
   logic [F-1:0]   f_a_ff, t_ff;
   logic [F+1:0]   w_ff, w_in;
   logic [2*F+1:0] tw;
   logic [F:0]     u_ff;

   always_comb begin
      w_in = {2'b11, {F{1'b0}}} - {1'b0, f_a_ff, 1'b0};
      tw   = (2*F+2)'(t_ff) * (2*F+2)'(w_ff);
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         t_raw_ff <= (2*F)'(f) * (2*F)'(f);
         f_a_ff   <= f;
         t_ff     <= t_raw_ff[2*F-1:F];
         w_ff     <= w_in;
         u_ff     <= tw[2*F:F];
      end
   end

   assign u = u_ff;
endmodule

/* design/ndag_blend.sv */
module ndag_blend #(
   parameter int F = 16
) (
   input  logic                clock,
   input  logic                ce,
   input  logic signed [F+1:0] a,
   input  logic signed [F+1:0] b,
   input  logic [F:0]          u,
   output logic signed [F+1:0] r
);
   logic [F:0] omu;
   logic signed [2*F+3:0] pa_ff, pb_ff;
   logic signed [2*F+4:0] sum;
   logic signed [F+1:0] r_ff;

   always_comb begin
      omu = {1'b1, {F{1'b0}}} - u;
      sum = (2*F+5)'(pa_ff) + (2*F+5)'(pb_ff);
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         pa_ff <= (2*F+4)'(a) * (2*F+4)'($signed({1'b0, omu}));
         pb_ff <= (2*F+4)'(b) * (2*F+4)'($signed({1'b0, u}));
         // bit select of the sum is a floor shift
         r_ff  <= sum[2*F+1:F];
      end
   end

   assign r = r_ff;
endmodule

/* design/ndag_sample.sv */
module ndag_sample #(
   parameter int F = 16
) (
   input  logic                       clock,
   input  logic                       ce,
   input  logic [ndag_pkg::LAT_W-1:0] ix,
   input  logic [ndag_pkg::LAT_W-1:0] iy,
   input  logic [F-1:0]               fx,
   input  logic [F-1:0]               fy,
   output logic signed [F+1:0]        noise
);
   logic signed [F+1:0] corner [4];
   logic signed [F+1:0] top_row, bot_row;
   logic [F:0] ux, uy;
   logic [F:0] ux_dly_ff [2];
   logic [F:0] uy_dly_ff [4];

   for (genvar c = 0; c < 4; c++) begin : g_corner
      ndag_hash #(.F(F)) u_hash (
         .clock (clock),
         .ce    (ce),
         .ix    (ix + ndag_pkg::LAT_W'(c % 2)),
         .iy    (iy + ndag_pkg::LAT_W'(c / 2)),
         .noise (corner[c])
      );
   end

   ndag_smooth #(.F(F)) u_smooth_x (.clock(clock), .ce(ce), .f(fx), .u(ux));
   ndag_smooth #(.F(F)) u_smooth_y (.clock(clock), .ce(ce), .f(fy), .u(uy));

   // line the weights up with the blend inputs: ux with the hash outputs, uy with the row results
   always_ff @(posedge clock) begin
      if (ce) begin
         ux_dly_ff[0] <= ux;
         ux_dly_ff[1] <= ux_dly_ff[0];
         uy_dly_ff[0] <= uy;
         uy_dly_ff[1] <= uy_dly_ff[0];
         uy_dly_ff[2] <= uy_dly_ff[1];
         uy_dly_ff[3] <= uy_dly_ff[2];
      end
   end

   ndag_blend #(.F(F)) u_blend_top (
      .clock(clock), .ce(ce), .a(corner[0]), .b(corner[1]), .u(ux_dly_ff[1]), .r(top_row)
   );
   ndag_blend #(.F(F)) u_blend_bot (
      .clock(clock), .ce(ce), .a(corner[2]), .b(corner[3]), .u(ux_dly_ff[1]), .r(bot_row)
   );
   ndag_blend #(.F(F)) u_blend_col (
      .clock(clock), .ce(ce), .a(top_row), .b(bot_row), .u(uy_dly_ff[3]), .r(noise)
   );
endmodule

/* design/noise_displacement_address_gen_unit.sv */
// throughput: one coordinate per cycle while rsp is not stalled, a fixed 14-stage pipeline with one clock enable
// the whole pipeline holds while a result waits on rsp
// reset (synchronous) empties the pipeline and loads width 4096, height 4096, scale 1.0
`include "noise_displacement_address_gen_unit_assert.svh"
module noise_displacement_address_gen_unit #(
   parameter int MAX_DIM       = 4096,
   parameter int FRACTION_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: pixel_x [11:0], pixel_y [23:12]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,
   // rsp_tdata: source_x [13:0], source_y [27:14], zero fill [31:28]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,
   // rsp_tuser: source_valid [0]
   output logic        rsp_tuser,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   localparam int F      = FRACTION_BITS;
   localparam int NS     = 14;           // pipeline stages, output register last
   localparam int PX_D   = 12;           // pixel delay to the add stage
   localparam int CW     = F + 8;        // sample coordinate width, Q8.F
   localparam int PW     = F + 19;       // noise times scale
   localparam longint unsigned OffX = (473 * (64'd1 << F) + 5) / 10;
   localparam longint unsigned OffY = (917 * (64'd1 << F) + 5) / 10;
   localparam logic [ndag_pkg::DIM_W-1:0] MaxDim = ndag_pkg::DIM_W'(MAX_DIM);

   // configuration registers
   logic [ndag_pkg::DIM_W-1:0]   width_ff, height_ff;
   logic [ndag_pkg::SCALE_W-1:0] scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= ndag_pkg::WIDTH_RESET;
         height_ff <= ndag_pkg::HEIGHT_RESET;
         scale_ff  <= ndag_pkg::SCALE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            ndag_pkg::REG_WIDTH:  width_ff  <= csr_wdata[ndag_pkg::DIM_W-1:0];
            ndag_pkg::REG_HEIGHT: height_ff <= csr_wdata[ndag_pkg::DIM_W-1:0];
            ndag_pkg::REG_SCALE:  scale_ff  <= csr_wdata;
            default: ; // no register at this index
         endcase
      end
   end

   // pipeline control: one enable for every stage
   logic [NS-1:0] valid_ff;
   logic pipe_ce;

   assign pipe_ce    = !valid_ff[NS-1] || rsp_tready;
   assign req_tready = pipe_ce;
   assign rsp_tvalid = valid_ff[NS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (pipe_ce) begin
         valid_ff <= {valid_ff[NS-2:0], req_tvalid};
      end
   end

   // destination pixel travels along to the add stage
   logic [ndag_pkg::PIX_W-1:0] px_pipe_ff [PX_D];
   logic [ndag_pkg::PIX_W-1:0] py_pipe_ff [PX_D];

   always_ff @(posedge clock) begin
      if (pipe_ce) begin
         px_pipe_ff[0] <= req_tdata[11:0];
         py_pipe_ff[0] <= req_tdata[23:12];
         for (int i = 1; i < PX_D; i++) begin
            px_pipe_ff[i] <= px_pipe_ff[i-1];
            py_pipe_ff[i] <= py_pipe_ff[i-1];
         end
      end
   end

   // stage 1: sample points, pixel/32 and the offset point for the y axis
   logic [CW-1:0] cx0, cy0, cx1, cy1;
   logic [ndag_pkg::LAT_W-1:0] ix_ff [2];
   logic [ndag_pkg::LAT_W-1:0] iy_ff [2];
   logic [F-1:0] fx_ff [2];
   logic [F-1:0] fy_ff [2];

   always_comb begin
      cx0 = CW'({px_pipe_ff[0], {(F-5){1'b0}}});
      cy0 = CW'({py_pipe_ff[0], {(F-5){1'b0}}});
      cx1 = cx0 + CW'(OffX);
      cy1 = cy0 + CW'(OffY);
   end

   always_ff @(posedge clock) begin
      if (pipe_ce) begin
         ix_ff[0] <= cx0[CW-1:F];
         iy_ff[0] <= cy0[CW-1:F];
         fx_ff[0] <= cx0[F-1:0];
         fy_ff[0] <= cy0[F-1:0];
         ix_ff[1] <= cx1[CW-1:F];
         iy_ff[1] <= cy1[CW-1:F];
         fx_ff[1] <= cx1[F-1:0];
         fy_ff[1] <= cy1[F-1:0];
      end
   end

   // stages 2 to 10: value noise per axis
   logic signed [F+1:0] noise [2];

   for (genvar a = 0; a < 2; a++) begin : g_axis
      ndag_sample #(.F(F)) u_sample (
         .clock (clock),
         .ce    (pipe_ce),
         .ix    (ix_ff[a]),
         .iy    (iy_ff[a]),
         .fx    (fx_ff[a]),
         .fy    (fy_ff[a]),
         .noise (noise[a])
      );
   end

   // stage 11: gain, stage 12: truncate toward zero and add, stage 13: bounds
   logic signed [PW-1:0] prod_ff [2];
   logic signed [PW-1:0] biased [2];
   logic [ndag_pkg::DISP_W-1:0] disp [2];
   logic signed [ndag_pkg::COORD_W-1:0] src_ff [2];
   logic signed [ndag_pkg::COORD_W-1:0] out_ff [2];
   logic out_ok_ff, ok_in;
   logic [ndag_pkg::DIM_W-1:0] w_eff, h_eff;

   always_comb begin
      for (int a = 0; a < 2; a++) begin
         biased[a] = prod_ff[a] + (prod_ff[a][PW-1] ? PW'((64'd1 << (F + 8)) - 1) : '0);
         disp[a]   = biased[a][F+17:F+8];
      end
      w_eff = (width_ff  > MaxDim) ? MaxDim : width_ff;
      h_eff = (height_ff > MaxDim) ? MaxDim : height_ff;
      ok_in = !src_ff[0][ndag_pkg::COORD_W-1] && (src_ff[0][12:0] < w_eff) &&
              !src_ff[1][ndag_pkg::COORD_W-1] && (src_ff[1][12:0] < h_eff);
   end

   always_ff @(posedge clock) begin
      if (pipe_ce) begin
         for (int a = 0; a < 2; a++) begin
            prod_ff[a] <= PW'(noise[a]) * PW'($signed({1'b0, scale_ff}));
            out_ff[a]  <= src_ff[a];
         end
         src_ff[0] <= $signed({2'b00, px_pipe_ff[PX_D-1]}) +
                      $signed({{4{disp[0][ndag_pkg::DISP_W-1]}}, disp[0]});
         src_ff[1] <= $signed({2'b00, py_pipe_ff[PX_D-1]}) +
                      $signed({{4{disp[1][ndag_pkg::DISP_W-1]}}, disp[1]});
         out_ok_ff <= ok_in;
      end
   end

   assign rsp_tdata = {4'b0000, out_ff[1], out_ff[0]};
   assign rsp_tuser = out_ok_ff;

   `NDAG_ASSERT(a_hold_on_stall, clock, reset, !pipe_ce |=> $stable(valid_ff))
   `NDAG_ASSERT(a_accept_enters, clock, reset, req_tvalid && req_tready |=> valid_ff[0])
   `NDAG_ASSERT(a_valid_nonneg, clock, reset, rsp_tvalid && rsp_tuser |-> !rsp_tdata[13] && !rsp_tdata[27])
   `NDAG_ASSERT_ALWAYS(a_reset_empties, clock, $past(reset) |-> valid_ff == '0)
endmodule
